// ===== hw/rtl/lwws_pkg.sv =====
package lwws_pkg;

	// coefficient and datapath widths
	localparam int COEF_BITS = 24;
	localparam int DATA_W    = 2 * COEF_BITS;   // one beat: re then im
	localparam int MAG_W     = 2 * COEF_BITS;   // |Y|^2, 16 fraction bits
	localparam int DVD_W     = 58;              // serial divider dividend / quotient
	localparam int DVS_W     = 32;              // serial divider divisor / remainder
	localparam int SQ_W      = 64;              // square root radicand
	localparam int RT_W      = SQ_W / 2;        // square root result
	localparam int SIG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// default sizing
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_WINDOW = 15;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOISE_SIGMA = 3'd0,
		REG_GAIN        = 3'd1,
		REG_BAND_WIDTH  = 3'd2,
		REG_BAND_HEIGHT = 3'd3,
		REG_WINDOW_SIZE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SIG_W-1:0] noise_sigma;
		logic [SIG_W-1:0] gain;
		logic [8:0]       band_width;
		logic [8:0]       band_height;
		logic [3:0]       window_size;
	} cfg_t;

	typedef struct packed {
		logic load;   // 1: store coefficient, 0: produce result
		logic last;   // final coefficient of the band
	} cmd_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RC,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_MEAN,
		ST_SQRT_D,
		ST_TDIV,
		ST_SQRT_X,
		ST_KEEP,
		ST_DIV_RE,
		ST_DIV_IM,
		ST_OUT
	} eng_state_t;

endpackage

// ===== hw/rtl/lwws_front.sv =====
module lwws_front #(
	parameter int AW = 16,
	parameter int DW = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [DW-1:0]                 w_eff,
	input  logic [DW-1:0]                 h_eff,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lwws_pkg::DATA_W-1:0]   s_tdata,   // coef_re, coef_im
	input  logic [0:0]                    s_tuser,   // mode
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output lwws_pkg::cmd_ctl_t            cmd_ctl,
	output logic [AW-1:0]                 cmd_addr,
	output logic [lwws_pkg::DATA_W-1:0]   cmd_data
);
	import lwws_pkg::*;

	localparam int PW  = AW + 1;
	localparam int QAW = $clog2(QUEUE_DEPTH);

	logic [PW-1:0]    load_ptr_q, emit_ptr_q, count;
	logic             accept, band_full, push, pop;
	cmd_ctl_t         push_ctl;
	logic [AW-1:0]    push_addr;

	cmd_ctl_t         q_ctl  [QUEUE_DEPTH];
	logic [AW-1:0]    q_addr [QUEUE_DEPTH];
	logic [DATA_W-1:0] q_data [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     fill_q;

	assign count     = PW'(w_eff * h_eff);
	assign band_full = (load_ptr_q >= count);
	assign s_tready  = (fill_q != QAW'(0) + (QAW+1)'(0)) ? (fill_q != (QAW+1)'(QUEUE_DEPTH)) : 1'b1;
	assign accept    = s_tvalid && s_tready;

	// classify the beat
	always_comb begin
		push          = 1'b0;
		push_ctl.load = 1'b0;
		push_ctl.last = 1'b0;
		push_addr     = load_ptr_q[AW-1:0];
		if (accept) begin
			if (!s_tuser[0]) begin
				push_ctl.load = 1'b1;
				push          = !band_full;
			end else if (band_full && (emit_ptr_q < count)) begin
				push          = 1'b1;
				push_addr     = emit_ptr_q[AW-1:0];
				push_ctl.last = (emit_ptr_q == count - PW'(1));
			end
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			emit_ptr_q <= '0;
		end else if (accept) begin
			if (!s_tuser[0]) begin
				if (!band_full) load_ptr_q <= load_ptr_q + PW'(1);
			end else if (band_full) begin
				if ((emit_ptr_q >= count) || (emit_ptr_q == count - PW'(1))) begin
					load_ptr_q <= '0;
					emit_ptr_q <= '0;
				end else begin
					emit_ptr_q <= emit_ptr_q + PW'(1);
				end
			end
		end
	end

	// command queue
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd_ctl   = q_ctl[rd_ptr_q];
	assign cmd_addr  = q_addr[rd_ptr_q];
	assign cmd_data  = q_data[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_ctl[wr_ptr_q]  <= push_ctl;
			q_addr[wr_ptr_q] <= push_addr;
			q_data[wr_ptr_q] <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QAW+1)'(1);
				2'b01:   fill_q <= fill_q - (QAW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lwws_div.sv =====
module lwws_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lwws_pkg::DVD_W-1:0]  dividend,
	input  logic [lwws_pkg::DVS_W-1:0]  divisor,
	output logic                        done,
	output logic [lwws_pkg::DVD_W-1:0]  quot,
	output logic [lwws_pkg::DVS_W-1:0]  rem
);
	import lwws_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q, rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DVS_W:0]   trial;
	logic             qbit;

	// one quotient bit a cycle, restoring
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/lwws_sqrt.sv =====
module lwws_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lwws_pkg::SQ_W-1:0]  radicand,
	output logic                       done,
	output logic [lwws_pkg::RT_W-1:0]  root,
	output logic                       inexact
);
	import lwws_pkg::*;

	localparam int CW = $clog2(RT_W + 1);

	logic [SQ_W-1:0] x_q;
	logic [RT_W-1:0] root_q;
	logic [RT_W:0]   rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q, done_q;
	logic [RT_W+2:0] trial_rem, trial;
	logic            take;

	// two radicand bits, one root bit a cycle
	assign trial_rem = {rem_q, x_q[SQ_W-1:SQ_W-2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign take      = (trial_rem >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQ_W-3:0], 2'b00};
			root_q <= {root_q[RT_W-2:0], take};
			rem_q  <= take ? (RT_W+1)'(trial_rem - trial) : trial_rem[RT_W:0];
		end
	end

	assign done    = done_q;
	assign root    = root_q;
	assign inexact = (rem_q != '0);

endmodule

// ===== hw/rtl/lwws_back.sv =====
module lwws_back #(
	parameter int AW  = 16,
	parameter int XW  = 8,
	parameter int WSW = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lwws_pkg::cfg_t               cfg,
	input  logic [XW:0]                  w_eff,
	input  logic [XW:0]                  h_eff,
	input  logic [WSW-1:0]               ws_eff,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  lwws_pkg::cmd_ctl_t           cmd_ctl,
	input  logic [AW-1:0]                cmd_addr,
	input  logic [lwws_pkg::DATA_W-1:0]  cmd_data,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lwws_pkg::DATA_W-1:0]  m_tdata,   // out_re, out_im
	output logic [0:0]                   m_tuser,   // kept
	output logic                         m_tlast
);
	import lwws_pkg::*;

	localparam int DEPTH = 2 ** AW;
	localparam int CB    = COEF_BITS;
	localparam int SUM_W = MAG_W + 2 * WSW;

	// band store, re in the low half
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_s1;
	logic              rd_vld_s1, rd_ctr_s1;
	logic [MAG_W-1:0]  mag_s2;
	logic              mag_vld_s2, mag_ctr_s2;

	eng_state_t        state_q, state_d;
	logic              mem_we, rd_issue, rd_ctr;
	logic [AW-1:0]     raddr, scan_addr;
	logic [2*XW:0]     row_base;

	logic              last_q;
	logic [XW-1:0]     rm_q, cm_q, cm0_q;
	logic              rup_q, cup_q, cup0_q;
	logic [WSW-1:0]    cnt_q, dx_q, dy_q;
	logic [SUM_W-1:0]  sum_q;
	logic signed [CB-1:0] ctr_re_q, ctr_im_q;
	logic [MAG_W-1:0]  ctr_mag_q;
	logic [DVD_W-1:0]  t_q;
	logic [RT_W-1:0]   s_q, num_q;
	logic              kept_q;
	logic [CB-1:0]     res_re_q, res_im_q;

	logic [2*SIG_W-1:0] s2_q;
	logic [3*SIG_W-1:0] gs2_q;

	logic              div_start, div_done, sq_start, sq_done, sq_inexact;
	logic [DVD_W-1:0]  div_dvd, div_quot, d_val;
	logic [DVS_W-1:0]  div_dvs, div_rem;
	logic [SQ_W-1:0]   sq_in;
	logic [RT_W-1:0]   sq_root, r_val;
	logic [2*WSW-1:0]  ww;
	logic [CB-1:0]     abs_re, abs_im;
	logic [CB+RT_W-1:0] prod_re, prod_im;
	logic signed [MAG_W-1:0] sq_re, sq_im;
	logic              last_dx, last_dy;

	m_tvalid_blk: begin end

	// reflected window walker: step the index by one, edge sample repeats
	function automatic logic [XW:0] walk(input logic [XW-1:0] m, input logic up,
		input logic fwd, input logic [XW:0] n);
		logic [XW-1:0] top;
		logic          hi_dir;
		logic [XW:0]   res;
		top    = XW'(n - (XW+1)'(1));
		hi_dir = (up == fwd);
		if (hi_dir) begin
			res = (m == top) ? {~up, m} : {up, m + XW'(1)};
		end else begin
			res = (m == '0) ? {~up, m} : {up, m - XW'(1)};
		end
		return res;
	endfunction

	lwws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	lwws_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root),
		.inexact  (sq_inexact)
	);

	// noise terms; config must be held static while work is in flight, which the block itself does not enforce
	always_ff @(posedge clk) begin
		s2_q  <= cfg.noise_sigma * cfg.noise_sigma;
		gs2_q <= cfg.gain * s2_q;
	end

	assign ww        = ws_eff * ws_eff;
	assign row_base  = rm_q * w_eff;
	assign scan_addr = AW'(row_base + (2*XW+1)'(cm_q));
	assign last_dx   = (dx_q == ws_eff - WSW'(1));
	assign last_dy   = (dy_q == ws_eff - WSW'(1));
	assign d_val     = (div_quot > DVD_W'(s2_q)) ? div_quot - DVD_W'(s2_q) : DVD_W'(1);
	assign r_val     = (sq_root == '0) ? RT_W'(1) : sq_root;
	assign abs_re    = ctr_re_q[CB-1] ? CB'(-ctr_re_q) : CB'(ctr_re_q);
	assign abs_im    = ctr_im_q[CB-1] ? CB'(-ctr_im_q) : CB'(ctr_im_q);
	assign prod_re   = abs_re * num_q;
	assign prod_im   = abs_im * num_q;

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		rd_issue  = 1'b0;
		rd_ctr    = 1'b0;
		raddr     = scan_addr;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		sq_start  = 1'b0;
		sq_in     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_ready = 1'b1;
					if (cmd_ctl.load) begin
						mem_we = 1'b1;
					end else begin
						rd_issue  = 1'b1;
						rd_ctr    = 1'b1;
						raddr     = cmd_addr;
						div_start = 1'b1;
						div_dvd   = DVD_W'(cmd_addr);
						div_dvs   = DVS_W'(w_eff);
						state_d   = ST_RC;
					end
				end
			end
			ST_RC: begin
				if (div_done) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (cnt_q == '0) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				rd_issue = 1'b1;
				if (last_dx && last_dy) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 && !mag_vld_s2) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(sum_q);
					div_dvs   = DVS_W'(ww);
					state_d   = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (div_done) begin
					sq_start = 1'b1;
					sq_in    = {d_val[SQ_W-9:0], 8'b0};
					state_d  = ST_SQRT_D;
				end
			end
			ST_SQRT_D: begin
				if (sq_done) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'({gs2_q, 4'b0});
					div_dvs   = DVS_W'(r_val);
					state_d   = ST_TDIV;
				end
			end
			ST_TDIV: begin
				if (div_done) begin
					sq_start = 1'b1;
					sq_in    = {ctr_mag_q, 16'b0};
					state_d  = ST_SQRT_X;
				end
			end
			ST_SQRT_X: begin
				if (sq_done) state_d = ST_KEEP;
			end
			ST_KEEP: begin
				if (kept_q) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(prod_re);
					div_dvs   = DVS_W'(s_q);
					state_d   = ST_DIV_RE;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV_RE: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(prod_im);
					div_dvs   = DVS_W'(s_q);
					state_d   = ST_DIV_IM;
				end
			end
			ST_DIV_IM: begin
				if (div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// store port
	always_ff @(posedge clk) begin
		if (mem_we) mem[cmd_addr] <= cmd_data;
		rd_data_s1 <= mem[raddr];
	end

	// read and square pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			mag_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_issue;
			mag_vld_s2 <= rd_vld_s1;
		end
	end

	assign sq_re = $signed(rd_data_s1[CB-1:0]) * $signed(rd_data_s1[CB-1:0]);
	assign sq_im = $signed(rd_data_s1[DATA_W-1:CB]) * $signed(rd_data_s1[DATA_W-1:CB]);

	always_ff @(posedge clk) begin
		rd_ctr_s1  <= rd_ctr;
		mag_ctr_s2 <= rd_ctr_s1;
		mag_s2     <= $unsigned(sq_re) + $unsigned(sq_im);
		if (rd_vld_s1 && rd_ctr_s1) begin
			ctr_re_q <= $signed(rd_data_s1[CB-1:0]);
			ctr_im_q <= $signed(rd_data_s1[DATA_W-1:CB]);
		end
		if (mag_vld_s2 && mag_ctr_s2) ctr_mag_q <= mag_s2;
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
		end else if (mag_vld_s2 && !mag_ctr_s2) begin
			sum_q <= sum_q + SUM_W'(mag_s2);
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !cmd_ctl.load) last_q <= cmd_ctl.last;
			end
			ST_RC: begin
				if (div_done) begin
					rm_q  <= div_quot[XW-1:0];
					cm_q  <= div_rem[XW-1:0];
					rup_q <= 1'b1;
					cup_q <= 1'b1;
					cnt_q <= ws_eff >> 1;
				end
			end
			ST_SETUP: begin
				if (cnt_q != '0) begin
					{rup_q, rm_q} <= walk(rm_q, rup_q, 1'b0, h_eff);
					{cup_q, cm_q} <= walk(cm_q, cup_q, 1'b0, w_eff);
					cnt_q         <= cnt_q - WSW'(1);
				end else begin
					cm0_q  <= cm_q;
					cup0_q <= cup_q;
					dx_q   <= '0;
					dy_q   <= '0;
				end
			end
			ST_SCAN: begin
				if (last_dx) begin
					dx_q          <= '0;
					dy_q          <= dy_q + WSW'(1);
					cm_q          <= cm0_q;
					cup_q         <= cup0_q;
					{rup_q, rm_q} <= walk(rm_q, rup_q, 1'b1, h_eff);
				end else begin
					dx_q          <= dx_q + WSW'(1);
					{cup_q, cm_q} <= walk(cm_q, cup_q, 1'b1, w_eff);
				end
			end
			ST_TDIV: begin
				if (div_done) t_q <= div_quot;
			end
			ST_SQRT_X: begin
				// T < |Y| exactly: below the root, or equal and not a perfect square
				if (sq_done) begin
					s_q    <= sq_root;
					num_q  <= sq_root - t_q[RT_W-1:0];
					kept_q <= (t_q < DVD_W'(sq_root)) ||
						((t_q == DVD_W'(sq_root)) && sq_inexact);
				end
			end
			ST_KEEP: begin
				if (!kept_q) begin
					res_re_q <= '0;
					res_im_q <= '0;
				end
			end
			ST_DIV_RE: begin
				if (div_done) begin
					res_re_q <= ctr_re_q[CB-1] ? -div_quot[CB-1:0] : div_quot[CB-1:0];
				end
			end
			ST_DIV_IM: begin
				if (div_done) begin
					res_im_q <= ctr_im_q[CB-1] ? -div_quot[CB-1:0] : div_quot[CB-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == ST_OUT) && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!m_tvalid || m_tready)) begin
			m_tdata <= {res_im_q, res_re_q};
			m_tuser <= kept_q;
			m_tlast <= last_q;
		end
	end

endmodule

// ===== hw/rtl/local_window_wavelet_shrink.sv =====
// Locally adaptive soft-threshold shrinkage of one complex wavelet subband.
// Mode 0 beats (tuser 0) load coefficients in raster order into an on-chip
// store of MAX_WIDTH x MAX_HEIGHT entries; once the band is full, each mode 1
// beat yields the next shrunk coefficient, with tlast on the final one.
// A front stage takes beats into a four-entry command queue and keeps the load
// and emit pointers; the back engine stores each load as it takes it and
// computes one result at a time, its pace set by the single store read port,
// which fetches the window one entry a cycle, and by the shared radix-2 divider
// (used for the row/column split, the mean, the threshold and each output
// component) and the radix-2 square root unit (used twice). Results wait in
// an output register, so the front keeps taking beats while the queue has
// room. Register writes are taken in any cycle but must only be made while
// the block is idle.
module local_window_wavelet_shrink #(
	parameter int MAX_WIDTH  = lwws_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lwws_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = lwws_pkg::DEF_MAX_WINDOW
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lwws_pkg::DATA_W-1:0]     s_tdata,   // coef_re, coef_im
	input  logic [0:0]                      s_tuser,   // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lwws_pkg::DATA_W-1:0]     m_tdata,   // out_re, out_im
	output logic [0:0]                      m_tuser,   // kept
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lwws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lwws_pkg::SIG_W-1:0]      cfg_data
);
	import lwws_pkg::*;

	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int XW      = $clog2(MAX_DIM);
	localparam int DW      = XW + 1;
	localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int WSW     = $clog2(MAX_WINDOW + 1);

	cfg_t              cfg_q;
	logic [DW-1:0]     w_eff, h_eff;
	logic [WSW-1:0]    ws_eff;
	logic              cmd_valid, cmd_ready;
	cmd_ctl_t          cmd_ctl;
	logic [AW-1:0]     cmd_addr;
	logic [DATA_W-1:0] cmd_data;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_sigma <= 16'd2560;
			cfg_q.gain        <= 16'd256;
			cfg_q.band_width  <= 9'd256;
			cfg_q.band_height <= 9'd256;
			cfg_q.window_size <= 4'd7;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_NOISE_SIGMA: cfg_q.noise_sigma <= cfg_data;
				REG_GAIN:        cfg_q.gain        <= cfg_data;
				REG_BAND_WIDTH:  cfg_q.band_width  <= cfg_data[8:0];
				REG_BAND_HEIGHT: cfg_q.band_height <= cfg_data[8:0];
				REG_WINDOW_SIZE: cfg_q.window_size <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// effective sizes: zero acts as one, oversize clamps
	always_comb begin
		if (cfg_q.band_width == '0)                 w_eff = DW'(1);
		else if (int'(cfg_q.band_width) > MAX_WIDTH) w_eff = DW'(MAX_WIDTH);
		else                                        w_eff = DW'(cfg_q.band_width);
		if (cfg_q.band_height == '0)                  h_eff = DW'(1);
		else if (int'(cfg_q.band_height) > MAX_HEIGHT) h_eff = DW'(MAX_HEIGHT);
		else                                          h_eff = DW'(cfg_q.band_height);
		if (cfg_q.window_size == '0)                   ws_eff = WSW'(1);
		else if (int'(cfg_q.window_size) > MAX_WINDOW) ws_eff = WSW'(MAX_WINDOW);
		else                                           ws_eff = WSW'(cfg_q.window_size);
	end

	lwws_front #(
		.AW (AW),
		.DW (DW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_ctl   (cmd_ctl),
		.cmd_addr  (cmd_addr),
		.cmd_data  (cmd_data)
	);

	lwws_back #(
		.AW  (AW),
		.XW  (XW),
		.WSW (WSW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.ws_eff    (ws_eff),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_ctl   (cmd_ctl),
		.cmd_addr  (cmd_addr),
		.cmd_data  (cmd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
